[hw/rtl/aarp_pkg.sv]
// Shared types and constants for the address relocation patcher.
// No dependencies; compiled first.
`default_nettype none

package aarp_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SCAN_MODE  = 2'd0,
		CFG_RANGE_LOW  = 2'd1,
		CFG_RANGE_HIGH = 2'd2,
		CFG_DELTA      = 2'd3
	} cfg_idx_t;

	// Scan modes
	localparam logic MODE_OPCODE = 1'b0;
	localparam logic MODE_WORD   = 1'b1;

	// Prefix opcodes that may precede an absolute address
	localparam logic [7:0] OPC_POP_ABS   = 8'h8F;
	localparam logic [7:0] OPC_PUSH_ABS  = 8'h9F;
	localparam logic [7:0] OPC_RANGE_LO  = 8'hE0;
	localparam logic [7:0] OPC_RANGE_HI  = 8'hEE;

	// Window geometry
	localparam int unsigned WIN_BYTES = 5;
	localparam logic [2:0] NEED_OPCODE = 3'd5;
	localparam logic [2:0] NEED_WORD   = 3'd4;
	localparam logic [2:0] FILL_MAX    = 3'd4;

	// Lock counts set by a patch
	localparam logic [2:0] LOCK_AFTER_OPCODE = 3'd4;
	localparam logic [2:0] LOCK_AFTER_WORD   = 3'd3;

	function automatic logic is_prefix_opcode(input logic [7:0] b);
		return (b == OPC_POP_ABS) || (b == OPC_PUSH_ABS) ||
			((b >= OPC_RANGE_LO) && (b <= OPC_RANGE_HI));
	endfunction

endpackage

`default_nettype wire

[hw/rtl/aarp_if.sv]
// Stream channel interfaces for the address relocation patcher.
// Input channel carries image bytes; output channel carries rewritten bytes.
`default_nettype none

interface aarp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface aarp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_patched;
	logic       out_last;

	modport source (output valid, output out_byte, output out_patched, output out_last,
		input ready);
	modport sink   (input valid, input out_byte, input out_patched, input out_last,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/absolute_address_relocation_patcher.sv]
// Top level of the address relocation patcher: byte window, match, patch, output register.
// Depends on aarp_pkg and the channel interfaces in aarp_if.sv.
//
// Channel     Dir  Handshake     Payload
// in_bytes    in   valid/ready   in_byte[7:0], in_last
// out_bytes   out  valid/ready   out_byte[7:0], out_patched, out_last
// cfg         in   cfg_we        cfg_idx[1:0], cfg_wdata[31:0]
//
// One byte per cycle unless stalled: each byte is inserted, matched, patched; once the
// window is full, one byte leaves. The byte with in_last is followed by a flush of the
// remaining window, one byte a cycle unless the output stalls, with in_bytes.ready low.
// Output stalls only hold the input when the next byte would emit a byte.
// Reset clears the window, counts, flush flag, output valid and configuration registers.
`default_nettype none

module absolute_address_relocation_patcher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [31:0] cfg_wdata,
	aarp_in_if.sink          in_bytes,
	aarp_out_if.source       out_bytes
);

	// Configuration registers
	logic        scan_mode_q;
	logic [31:0] range_low_q;
	logic [31:0] range_high_q;
	logic [31:0] delta_q;

	// Window state
	logic [39:0] win_q;
	logic [2:0]  fill_q;
	logic [2:0]  lock_q;
	logic        drain_q;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_patched_q;
	logic        out_last_q;

	// Step logic
	logic [2:0]  fill_c;
	logic [2:0]  fill_inc;
	logic [2:0]  need;
	logic        will_emit;
	logic [39:0] win_ins;
	logic [39:0] win_pat;
	logic [31:0] word;
	logic [31:0] sum;
	logic        in_range;
	logic        opcode_ok;
	logic        hit;
	logic        emit_patched;
	logic [39:0] win_nxt;
	logic [2:0]  fill_nxt;
	logic [2:0]  lock_nxt;
	logic        in_acc;
	logic        out_load_ok;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q  <= aarp_pkg::MODE_OPCODE;
			range_low_q  <= '0;
			range_high_q <= '0;
			delta_q      <= '0;
		end else if (cfg_we) begin
			unique case (aarp_pkg::cfg_idx_t'(cfg_idx))
				aarp_pkg::CFG_SCAN_MODE:  scan_mode_q  <= cfg_wdata[0];
				aarp_pkg::CFG_RANGE_LOW:  range_low_q  <= cfg_wdata;
				aarp_pkg::CFG_RANGE_HIGH: range_high_q <= cfg_wdata;
				aarp_pkg::CFG_DELTA:      delta_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Insert the new byte, match and patch
	always_comb begin
		fill_c    = (fill_q > aarp_pkg::FILL_MAX) ? aarp_pkg::FILL_MAX : fill_q;
		fill_inc  = fill_c + 3'd1;
		need      = (scan_mode_q == aarp_pkg::MODE_WORD) ? aarp_pkg::NEED_WORD
			: aarp_pkg::NEED_OPCODE;
		will_emit = (fill_inc >= need);

		for (int i = 0; i < aarp_pkg::WIN_BYTES; i++) begin
			if (3'(i) < fill_c)
				win_ins[i*8 +: 8] = win_q[i*8 +: 8];
			else if (3'(i) == fill_c)
				win_ins[i*8 +: 8] = in_bytes.in_byte;
			else
				win_ins[i*8 +: 8] = 8'h00;
		end

		word      = (scan_mode_q == aarp_pkg::MODE_WORD) ? win_ins[31:0] : win_ins[39:8];
		in_range  = (word >= range_low_q) && (word < range_high_q);
		opcode_ok = (scan_mode_q == aarp_pkg::MODE_WORD) ||
			aarp_pkg::is_prefix_opcode(win_ins[7:0]);
		hit       = will_emit && (lock_q == 3'd0) && in_range && opcode_ok;
		sum       = word + delta_q;

		win_pat = win_ins;
		if (hit) begin
			if (scan_mode_q == aarp_pkg::MODE_WORD)
				win_pat[31:0] = sum;
			else
				win_pat[39:8] = sum;
		end

		// opcode byte itself is not flagged; in word mode the first byte is
		emit_patched = hit ? scan_mode_q : (lock_q != 3'd0);

		if (will_emit) begin
			win_nxt  = {8'h00, win_pat[39:8]};
			fill_nxt = fill_inc - 3'd1;
			if (hit)
				lock_nxt = (scan_mode_q == aarp_pkg::MODE_WORD) ?
					aarp_pkg::LOCK_AFTER_WORD : aarp_pkg::LOCK_AFTER_OPCODE;
			else
				lock_nxt = (lock_q != 3'd0) ? lock_q - 3'd1 : 3'd0;
		end else begin
			win_nxt  = win_ins;
			fill_nxt = fill_inc;
			lock_nxt = lock_q;
		end
	end

	// Handshake
	assign out_load_ok    = !out_valid_q || out_bytes.ready;
	assign in_bytes.ready = !drain_q && (!will_emit || out_load_ok);
	assign in_acc         = in_bytes.valid && in_bytes.ready;

	// Window state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			fill_q      <= '0;
			lock_q      <= '0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			win_q   <= win_nxt;
			fill_q  <= fill_nxt;
			lock_q  <= lock_nxt;
			drain_q <= in_bytes.in_last;
			if (will_emit)
				out_valid_q <= 1'b1;
			else if (out_bytes.ready)
				out_valid_q <= 1'b0;
		end else if (drain_q && out_load_ok) begin
			// flush one pending byte of the finished span
			out_valid_q <= 1'b1;
			if (fill_q == 3'd1) begin
				win_q   <= '0;
				fill_q  <= '0;
				lock_q  <= '0;
				drain_q <= 1'b0;
			end else begin
				win_q  <= {8'h00, win_q[39:8]};
				fill_q <= fill_q - 3'd1;
				lock_q <= (lock_q != 3'd0) ? lock_q - 3'd1 : 3'd0;
			end
		end else if (out_bytes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (in_acc && will_emit) begin
			out_byte_q    <= win_pat[7:0];
			out_patched_q <= emit_patched;
			out_last_q    <= 1'b0;
		end else if (!in_acc && drain_q && out_load_ok) begin
			out_byte_q    <= win_q[7:0];
			out_patched_q <= (lock_q != 3'd0);
			out_last_q    <= (fill_q == 3'd1);
		end
	end

	assign out_bytes.valid       = out_valid_q;
	assign out_bytes.out_byte    = out_byte_q;
	assign out_bytes.out_patched = out_patched_q;
	assign out_bytes.out_last    = out_last_q;

	// Checks
	a_lock_within_fill: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q <= fill_q)
		else $error("lock count exceeds window fill");

	a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		!(drain_q && in_bytes.ready))
		else $error("input ready during flush");

	a_last_starts_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_bytes.in_last) |=> drain_q)
		else $error("span end did not start a flush");

	a_flush_ends_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q && !in_acc && out_load_ok && fill_q == 3'd1) |=>
		(out_valid_q && out_last_q && !drain_q && fill_q == 3'd0))
		else $error("flush did not close with a last word");

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && will_emit) |-> out_load_ok)
		else $error("word emitted into a full output register");

endmodule

`default_nettype wire
